// File: rtl/sstq_pkg.sv
`timescale 1ns / 1ps
package sstq_pkg;
    localparam int NumTimers = 16;
    localparam int TickBits  = 32;
    localparam int IdBits    = 4;
    localparam int CntBits   = 5;

    typedef logic [TickBits-1:0] t_tick;
    typedef logic [IdBits-1:0]   t_id;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_ONESHOT  = 2'd1;
    localparam logic [1:0] OP_PERIODIC = 2'd2;
    localparam logic [1:0] OP_CANCEL   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_IGNORED   = 2'd2;

    // list command broadcast to every cell
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_REMOVE
    } t_cmd;

    typedef struct packed {
        t_cmd  cmd;
        t_id   id;
        t_tick deadline;
    } t_list_ctl;

    // what a cell shows to its neighbors
    typedef struct packed {
        logic  valid;
        t_id   id;
        t_tick deadline;
    } t_cell;
endpackage

// File: rtl/sstq_cell.sv
`timescale 1ns / 1ps
module sstq_cell
    import sstq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_list_ctl i_ctl,
    input  t_cell     i_left,
    input  logic      i_left_ins,   // insert position lies at or left of the left cell
    input  logic      i_left_rm,    // removed entry lies left of this cell
    input  t_cell     i_right,
    output t_cell     o_cell,
    output logic      o_ins,
    output logic      o_rm
);
    t_cell r_cell;
    t_cell n_cell;
    logic  w_here_ins;

    // new entry goes before the first cell that is empty or has a larger deadline
    assign w_here_ins = !r_cell.valid || (i_ctl.deadline < r_cell.deadline);
    assign o_ins = i_left_ins || w_here_ins;
    assign o_rm  = i_left_rm || (r_cell.valid && r_cell.id == i_ctl.id);
    assign o_cell = r_cell;

    always_comb begin
        n_cell = r_cell;
        case (i_ctl.cmd)
            CMD_INSERT: begin
                if (i_left_ins) begin
                    n_cell = i_left;
                end else if (w_here_ins) begin
                    n_cell.valid    = 1'b1;
                    n_cell.id       = i_ctl.id;
                    n_cell.deadline = i_ctl.deadline;
                end
            end
            CMD_REMOVE: begin
                if (o_rm) begin
                    n_cell = i_right;
                end
            end
            default: begin
                n_cell = r_cell;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= n_cell.valid;
        end
        r_cell.id       <= n_cell.id;
        r_cell.deadline <= n_cell.deadline;
    end
endmodule

// File: rtl/sstq_list.sv
`timescale 1ns / 1ps
module sstq_list
    import sstq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_list_ctl i_ctl,
    output t_cell     o_head
);
    t_cell w_cell [NumTimers];
    logic  w_ins  [NumTimers];
    logic  w_rm   [NumTimers];

    for (genvar g = 0; g < NumTimers; g++) begin : g_cell
        t_cell w_left;
        t_cell w_right;
        logic  w_lins;
        logic  w_lrm;
        if (g == 0) begin : g_first
            assign w_left = '0;
            assign w_lins = 1'b0;
            assign w_lrm  = 1'b0;
        end else begin : g_mid
            assign w_left = w_cell[g-1];
            assign w_lins = w_ins[g-1];
            assign w_lrm  = w_rm[g-1];
        end
        if (g == NumTimers - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_nxt
            assign w_right = w_cell[g+1];
        end
        sstq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (i_ctl),
            .i_left     (w_left),
            .i_left_ins (w_lins),
            .i_left_rm  (w_lrm),
            .i_right    (w_right),
            .o_cell     (w_cell[g]),
            .o_ins      (w_ins[g]),
            .o_rm       (w_rm[g])
        );
    end

    assign o_head = w_cell[0];
endmodule

// File: rtl/sorted_software_timer_queue.sv
`timescale 1ns / 1ps
// Sorted timer queue: a chain of NumTimers cells keeps slots in deadline order.
// Register issues list remove (if the slot is active), then insert, then its result;
// cancel answers from idle. Tick advances time and pops each expired head, re-inserting
// a periodic one; a tick while stopped is ignored. A new item is taken only in idle with
// no list command pending; the next input transfer can share the edge where the final
// result leaves. Sync active-low reset empties list.
module sorted_software_timer_queue
    import sstq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // operation[1:0], timer_id[5:2], delay[37:6]
    input  logic        m_axis_tready,
    output logic        m_axis_tvalid,
    output logic [7:0]  m_axis_tdata,  // fired_id[3:0], status[5:4]
    output logic        m_axis_tuser,  // kind
    output logic        m_axis_tlast   // last
);
    typedef enum logic [2:0] {
        S_IDLE, S_REMOVE, S_INSERT, S_CHECK, S_REARM, S_DONE, S_WAIT
    } t_state;

    t_state r_state;
    t_state r_after;      // state after the output transfer
    logic   r_running;
    t_tick  r_now;
    logic   [NumTimers-1:0] r_active;
    logic   [NumTimers-1:0] r_periodic;
    t_tick  r_period [NumTimers];
    logic   [1:0]  r_op;
    t_id    r_id;
    t_tick  r_delay;
    logic   [CntBits-1:0] r_fires;
    t_list_ctl r_ctl;     // one-cycle command to the cell chain
    logic   r_ovalid;
    logic   [3:0] r_ofid;
    logic   [1:0] r_ostat;
    logic   r_okind;
    logic   r_olast;

    t_cell w_head;
    logic  [1:0]  w_op;
    t_id   w_id;
    t_tick w_delay;
    logic  w_idok;

    assign w_op    = s_axis_tdata[1:0];
    assign w_id    = s_axis_tdata[5:2];
    assign w_delay = s_axis_tdata[37:6];
    assign w_idok  = 1'b1;  // every 4-bit id addresses one of the 16 slots

    sstq_list u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl),
        .o_head  (w_head)
    );

    // a result leaving this cycle frees the output register for the new item
    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready)
                           && (r_ctl.cmd == CMD_NONE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_ostat, r_ofid};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_after   <= S_IDLE;
            r_running <= 1'b0;
            r_now     <= '0;
            r_active  <= '0;
            r_ctl.cmd <= CMD_NONE;
            r_ovalid  <= 1'b0;
            r_fires   <= '0;
        end else begin
            r_ctl.cmd <= CMD_NONE;
            if (i_cfg_we) begin
                r_running <= i_cfg_wdata;
            end
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op    <= w_op;
                        r_id    <= w_id;
                        r_delay <= w_delay;
                        r_fires <= '0;
                        if (w_op == OP_TICK) begin
                            if (r_running) begin
                                r_now   <= r_now + 1'b1;
                                r_state <= S_CHECK;
                            end else begin
                                r_ovalid <= 1'b1;
                                r_okind  <= 1'b0;
                                r_ofid   <= '0;
                                r_ostat  <= ST_IGNORED;
                                r_olast  <= 1'b1;
                            end
                        end else if (w_op == OP_CANCEL) begin
                            r_ovalid <= 1'b1;
                            r_okind  <= 1'b0;
                            r_ofid   <= '0;
                            r_olast  <= 1'b1;
                            if (w_idok && r_active[w_id]) begin
                                r_ostat      <= ST_OK;
                                r_active[w_id] <= 1'b0;
                                r_ctl.cmd    <= CMD_REMOVE;
                                r_ctl.id     <= w_id;
                            end else begin
                                r_ostat <= ST_NOT_FOUND;
                            end
                        end else begin
                            r_ctl.cmd <= r_active[w_id] ? CMD_REMOVE : CMD_NONE;
                            r_ctl.id  <= w_id;
                            r_state   <= S_INSERT;
                        end
                    end
                end
                S_INSERT: begin
                    // register: list remove (if any) done, now insert
                    r_active[r_id]   <= 1'b1;
                    r_periodic[r_id] <= (r_op == OP_PERIODIC);
                    if (r_op == OP_PERIODIC && r_delay == '0) begin
                        r_period[r_id]  <= t_tick'(1);
                        r_ctl.deadline  <= r_now + t_tick'(1);
                    end else begin
                        r_period[r_id]  <= r_delay;
                        r_ctl.deadline  <= r_now + r_delay;
                    end
                    r_ctl.cmd <= CMD_INSERT;
                    r_ctl.id  <= r_id;
                    r_state   <= S_DONE;
                end
                S_CHECK: begin
                    if (!r_ovalid || m_axis_tready) begin
                        if (w_head.valid && w_head.deadline <= r_now
                                && r_fires != CntBits'(NumTimers)) begin
                            r_ovalid  <= 1'b1;
                            r_okind   <= 1'b1;
                            r_ofid    <= w_head.id;
                            r_ostat   <= ST_OK;
                            r_olast   <= 1'b0;
                            r_fires   <= r_fires + 1'b1;
                            r_ctl.cmd <= CMD_REMOVE;
                            r_ctl.id  <= w_head.id;
                            r_id      <= w_head.id;
                            if (r_periodic[w_head.id]) begin
                                r_state <= S_REARM;
                            end else begin
                                r_active[w_head.id] <= 1'b0;
                                r_state <= S_WAIT;
                            end
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_REARM: begin
                    r_ctl.cmd      <= CMD_INSERT;
                    r_ctl.id       <= r_id;
                    r_ctl.deadline <= r_now + r_period[r_id];
                    r_state        <= S_WAIT;
                end
                S_WAIT: begin
                    r_state <= S_CHECK;
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= 1'b0;
                        r_ofid   <= '0;
                        r_ostat  <= ST_OK;
                        r_olast  <= 1'b1;
                        r_state  <= r_after;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
